### rtl/core/mp2_pkg.sv
// Shared types, constants and register indexes of the 2-D max pooling stream block.
package mp2_pkg;

    localparam int MAX_WIDTH    = 256;
    localparam int MAX_KERNEL   = 4;
    localparam int MAX_CHANNELS = 1024;

    localparam int PIX_W  = 8;
    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int LANES  = MAX_KERNEL;
    localparam int LANE_W = $clog2(MAX_KERNEL);
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);

    localparam logic [2:0] REG_CHANNEL_COUNT = 3'd0;
    localparam logic [2:0] REG_MAP_HEIGHT    = 3'd1;
    localparam logic [2:0] REG_MAP_WIDTH     = 3'd2;
    localparam logic [2:0] REG_WINDOW_SIZE   = 3'd3;
    localparam logic [2:0] REG_STEP_SIZE     = 3'd4;
    localparam logic [2:0] REG_ROUND_UP_MODE = 3'd5;
    localparam logic [2:0] REG_POOL_ENABLE   = 3'd6;

    localparam logic signed [PIX_W-1:0] POOL_FLOOR = 8'sh80;

    typedef struct packed {
        logic [10:0] ch_n;
        logic [8:0]  h;
        logic [8:0]  w;
        logic [2:0]  k;
        logic [2:0]  s;
        logic [8:0]  oh_n;
        logic [8:0]  ow_n;
        logic        enable;
    } geom_t;

    typedef struct packed {
        logic                    valid;
        logic [ADDR_W-1:0]       addr;
        logic signed [PIX_W-1:0] hmax;
        logic [LANES-1:0]        act;
        logic [LANES-1:0]        first;
        logic                    emit;
        logic [LANE_W-1:0]       lane;
        logic                    plane;
        logic                    frame;
    } stage_t;

endpackage

### rtl/core/mp2_cfg.sv
// Configuration registers and derived pooling geometry.
module mp2_cfg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [2:0]          cfg_addr,
    input  logic [10:0]         cfg_wr_data,
    output logic                restart,
    output mp2_pkg::geom_t      geom
);

    logic [10:0] chan_reg;
    logic [8:0]  height_reg;
    logic [8:0]  width_reg;
    logic [2:0]  win_reg;
    logic [2:0]  step_reg;
    logic        ceil_reg;
    logic        enable_reg;

    logic [2:0]  k_tmp;
    logic [2:0]  k;
    logic [2:0]  s;
    logic [8:0]  h;
    logic [8:0]  w;

    function automatic logic [8:0] axis_count(input logic [8:0] n, input logic [2:0] kk,
                                              input logic [2:0] ss, input logic up);
        logic [9:0]  x;
        logic [17:0] prod;
        logic [8:0]  q;
        begin
            x    = {1'b0, n} - {7'd0, kk} + (up ? {7'd0, ss} - 10'd1 : 10'd0);
            prod = x * 18'd171;
            case (ss)
                3'd2: q = x[9:1];
                3'd3: q = prod[17:9];
                3'd4: q = x[9:2];
                default: q = x[8:0];
            endcase
            axis_count = q + 9'd1;
        end
    endfunction

    assign restart = cfg_wr_en && (cfg_addr <= mp2_pkg::REG_POOL_ENABLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chan_reg   <= 11'd1;
            height_reg <= 9'd1;
            width_reg  <= 9'd1;
            win_reg    <= 3'd1;
            step_reg   <= 3'd1;
            ceil_reg   <= 1'b0;
            enable_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                mp2_pkg::REG_CHANNEL_COUNT: chan_reg   <= cfg_wr_data;
                mp2_pkg::REG_MAP_HEIGHT:    height_reg <= cfg_wr_data[8:0];
                mp2_pkg::REG_MAP_WIDTH:     width_reg  <= cfg_wr_data[8:0];
                mp2_pkg::REG_WINDOW_SIZE:   win_reg    <= cfg_wr_data[2:0];
                mp2_pkg::REG_STEP_SIZE:     step_reg   <= cfg_wr_data[2:0];
                mp2_pkg::REG_ROUND_UP_MODE: ceil_reg   <= cfg_wr_data[0];
                mp2_pkg::REG_POOL_ENABLE:   enable_reg <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        h = (height_reg == 9'd0) ? 9'd1 : height_reg;
        w = (width_reg == 9'd0) ? 9'd1 : width_reg;
        k_tmp = (win_reg == 3'd0) ? 3'd1 :
                (win_reg > 3'(mp2_pkg::MAX_KERNEL)) ? 3'(mp2_pkg::MAX_KERNEL) : win_reg;
        k = k_tmp;
        if ({6'd0, k} > h) k = h[2:0];
        if ({6'd0, k} > w) k = w[2:0];
        s = (step_reg == 3'd0) ? 3'd1 : (step_reg > k) ? k : step_reg;
        geom.ch_n = (chan_reg == 11'd0) ? 11'd1 :
                    (chan_reg > 11'(mp2_pkg::MAX_CHANNELS)) ? 11'(mp2_pkg::MAX_CHANNELS)
                                                            : chan_reg;
        geom.h      = h;
        geom.w      = w;
        geom.k      = k;
        geom.s      = s;
        geom.oh_n   = axis_count(h, k, s, ceil_reg);
        geom.ow_n   = axis_count(w, k, s, ceil_reg);
        geom.enable = enable_reg;
    end

endmodule

### rtl/core/mp2_ctrl.sv
// Position counters, row window of recent pixels and window tracking per request.
module mp2_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       restart,
    input  logic                       accept,
    input  logic signed [7:0]          pixel,
    input  mp2_pkg::geom_t             geom,
    output mp2_pkg::stage_t            st
);

    logic signed [7:0] rp_reg [mp2_pkg::MAX_KERNEL];
    logic signed [7:0] rp_new [mp2_pkg::MAX_KERNEL];
    logic [7:0] col_reg;
    logic [8:0] hwin_reg;
    logic [7:0] row_reg;
    logic [8:0] lo_reg;
    logic [8:0] hi_reg;
    logic [9:0] histart_reg;
    logic [9:0] chan_reg;
    logic [8:0] orow_reg;
    logic [8:0] ocol_reg;

    logic [9:0] hend;
    logic [9:0] loend;
    logic [9:0] oend;
    logic [9:0] col_last;
    logic [9:0] row_last;
    logic [9:0] c_end;
    logic [9:0] r_end;
    logic       hmatch;
    logic [9:0] diff;
    logic [2:0] cnt;
    logic signed [7:0] m;
    logic [8:0] hi_c;
    logic [9:0] oh;
    logic       row_done;
    logic       plane_done;

    always_comb begin
        hend  = ({1'b0, hwin_reg} * {7'd0, geom.s}) + {7'd0, geom.k} - 10'd1;
        loend = ({1'b0, lo_reg} * {7'd0, geom.s}) + {7'd0, geom.k} - 10'd1;
        oend  = ({1'b0, orow_reg} * {7'd0, geom.s}) + {7'd0, geom.k} - 10'd1;
        rp_new[0] = pixel;
        for (int i = 1; i < mp2_pkg::MAX_KERNEL; i++) rp_new[i] = rp_reg[i-1];
        col_last = {1'b0, geom.w - 9'd1};
        row_last = {1'b0, geom.h - 9'd1};
        c_end  = (hend > col_last) ? col_last : hend;
        r_end  = (oend > row_last) ? row_last : oend;
        hmatch = ({2'd0, col_reg} == c_end) && (hwin_reg < geom.ow_n);
        diff   = hend - {2'd0, col_reg};
        cnt    = geom.k - diff[2:0];
        m = mp2_pkg::POOL_FLOOR;
        for (int i = 0; i < mp2_pkg::MAX_KERNEL; i++) begin
            if ((3'(i) < cnt) && (rp_new[i] > m)) m = rp_new[i];
        end
        hi_c = (hi_reg > geom.oh_n - 9'd1) ? geom.oh_n - 9'd1 : hi_reg;
        st.act   = '0;
        st.first = '0;
        for (int d = 0; d < mp2_pkg::LANES; d++) begin
            oh = {1'b0, lo_reg} + 10'(d);
            if (hmatch && (oh <= {1'b0, hi_c})) begin
                st.act[oh[mp2_pkg::LANE_W-1:0]]   = 1'b1;
                st.first[oh[mp2_pkg::LANE_W-1:0]] =
                    (oh == {1'b0, hi_reg}) && ({2'd0, row_reg} == histart_reg);
            end
        end
        st.valid = accept && hmatch;
        st.addr  = hwin_reg[mp2_pkg::ADDR_W-1:0];
        st.hmax  = m;
        st.emit  = hmatch && (orow_reg < geom.oh_n) && (hwin_reg == ocol_reg) &&
                   ({2'd0, row_reg} == r_end);
        st.lane  = orow_reg[mp2_pkg::LANE_W-1:0];
        st.plane = (orow_reg == geom.oh_n - 9'd1) && (ocol_reg == geom.ow_n - 9'd1);
        st.frame = st.plane && ({1'b0, chan_reg} == geom.ch_n - 11'd1);
        row_done   = ({1'b0, col_reg} + 9'd1) >= geom.w;
        plane_done = ({1'b0, row_reg} + 9'd1) >= geom.h;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            for (int i = 0; i < mp2_pkg::MAX_KERNEL; i++) rp_reg[i] <= '0;
            col_reg     <= '0;
            hwin_reg    <= '0;
            row_reg     <= '0;
            lo_reg      <= '0;
            hi_reg      <= '0;
            histart_reg <= '0;
            chan_reg    <= '0;
            orow_reg    <= '0;
            ocol_reg    <= '0;
        end else if (accept) begin
            if (st.emit) begin
                if (ocol_reg + 9'd1 >= geom.ow_n) begin
                    ocol_reg <= '0;
                    orow_reg <= orow_reg + 9'd1;
                end else begin
                    ocol_reg <= ocol_reg + 9'd1;
                end
            end
            if (row_done) begin
                for (int i = 0; i < mp2_pkg::MAX_KERNEL; i++) rp_reg[i] <= '0;
                col_reg  <= '0;
                hwin_reg <= '0;
                if (plane_done) begin
                    row_reg     <= '0;
                    lo_reg      <= '0;
                    hi_reg      <= '0;
                    histart_reg <= '0;
                    orow_reg    <= '0;
                    ocol_reg    <= '0;
                    chan_reg    <= ({1'b0, chan_reg} + 11'd1 >= geom.ch_n) ? '0
                                                                          : chan_reg + 10'd1;
                end else begin
                    row_reg <= row_reg + 8'd1;
                    if (loend == {2'd0, row_reg}) begin
                        lo_reg <= lo_reg + 9'd1;
                    end
                    if ({2'd0, row_reg} + 10'd1 == histart_reg + {7'd0, geom.s}) begin
                        hi_reg      <= hi_reg + 9'd1;
                        histart_reg <= histart_reg + {7'd0, geom.s};
                    end
                end
            end else begin
                for (int i = 0; i < mp2_pkg::MAX_KERNEL; i++) rp_reg[i] <= rp_new[i];
                col_reg <= col_reg + 8'd1;
                if (hmatch) begin
                    hwin_reg <= hwin_reg + 9'd1;
                end
            end
        end
    end

endmodule

### rtl/core/mp2_colmem.sv
// Column partial-max memory with read-merge-write and same-entry forwarding.
module mp2_colmem (
    input  logic                aclk,
    input  logic                aresetn,
    input  mp2_pkg::stage_t     st,
    output logic                push,
    output logic [9:0]          push_data,
    output logic                busy
);

    localparam int WORD_W = mp2_pkg::LANES * mp2_pkg::PIX_W;

    logic [WORD_W-1:0] mem [mp2_pkg::MAX_WIDTH];
    logic [WORD_W-1:0] rd_data_reg;
    logic [WORD_W-1:0] fwd_data_reg;
    logic              fwd_reg;
    mp2_pkg::stage_t   s1_reg;

    logic [WORD_W-1:0] src;
    logic [WORD_W-1:0] merged;
    logic signed [7:0] old;

    always_comb begin
        src = fwd_reg ? fwd_data_reg : rd_data_reg;
        for (int j = 0; j < mp2_pkg::LANES; j++) begin
            old = src[j*mp2_pkg::PIX_W +: mp2_pkg::PIX_W];
            if (s1_reg.act[j] && (s1_reg.first[j] || (old < s1_reg.hmax)))
                merged[j*mp2_pkg::PIX_W +: mp2_pkg::PIX_W] = s1_reg.hmax;
            else
                merged[j*mp2_pkg::PIX_W +: mp2_pkg::PIX_W] = old;
        end
        push      = s1_reg.valid && s1_reg.emit;
        push_data = {s1_reg.frame, s1_reg.plane,
                     merged[s1_reg.lane*mp2_pkg::PIX_W +: mp2_pkg::PIX_W]};
        busy      = push;
    end

    always_ff @(posedge aclk) begin
        if (st.valid) rd_data_reg <= mem[st.addr];
        if (s1_reg.valid) mem[s1_reg.addr] <= merged;
    end

    always_ff @(posedge aclk) begin
        fwd_data_reg <= merged;
        if (!aresetn) begin
            s1_reg  <= '0;
            fwd_reg <= 1'b0;
        end else begin
            s1_reg  <= st;
            fwd_reg <= st.valid && s1_reg.valid && (st.addr == s1_reg.addr);
        end
    end

endmodule

### rtl/core/mp2_outq.sv
// Output result queue feeding the master side.
module mp2_outq (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  logic [9:0]  push_data,
    input  logic        pop,
    output logic        valid,
    output logic [9:0]  head,
    output logic [mp2_pkg::OUTQ_PTR_W:0] count
);

    logic [9:0] q_mem [mp2_pkg::OUTQ_DEPTH];
    logic [mp2_pkg::OUTQ_PTR_W-1:0] wptr_reg;
    logic [mp2_pkg::OUTQ_PTR_W-1:0] rptr_reg;
    logic [mp2_pkg::OUTQ_PTR_W:0]   cnt_reg;

    assign valid = cnt_reg != '0;
    assign head  = q_mem[rptr_reg];
    assign count = cnt_reg;

    always_ff @(posedge aclk) begin
        if (push) q_mem[wptr_reg] <= push_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (push) wptr_reg <= wptr_reg + mp2_pkg::OUTQ_PTR_W'(1);
            if (pop) rptr_reg <= rptr_reg + mp2_pkg::OUTQ_PTR_W'(1);
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + (mp2_pkg::OUTQ_PTR_W+1)'(1);
                2'b01:   cnt_reg <= cnt_reg - (mp2_pkg::OUTQ_PTR_W+1)'(1);
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

### rtl/core/max_pool_2d_stream.sv
// Top level of the streaming 2-D max pooling block.
//   channel   dir  payload
//   s_*       in   tdata[7:0] pixel_value
//   m_*       out  tdata[7:0] pooled_value, tlast plane_end, tuser frame_end
//   cfg_*     in   write-only register port, index 0..6
// One pixel per cycle while s_tready is high; results pass s1_reg, then the output queue.
// Rate is set by the single read-merge-write pass on the column memory per pixel.
// aresetn is synchronous; no clearing pass, partial maxima are written before read.
// s_tready drops only when the four-entry output queue plus the result in flight is full.
module max_pool_2d_stream (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] pixel_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] pooled_value
    output logic        m_tlast,
    output logic        m_tuser,    // [0] frame_end
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [10:0] cfg_wr_data
);

    mp2_pkg::geom_t  geom;
    mp2_pkg::stage_t st;
    logic            restart;
    logic            accept;
    logic            push;
    logic [9:0]      push_data;
    logic            busy;
    logic [9:0]      head;
    logic [mp2_pkg::OUTQ_PTR_W:0] q_count;

    assign s_tready = ({1'b0, q_count} + {{(mp2_pkg::OUTQ_PTR_W+1){1'b0}}, busy})
                      < (mp2_pkg::OUTQ_PTR_W+2)'(mp2_pkg::OUTQ_DEPTH);
    assign accept   = s_tvalid && s_tready && geom.enable;
    assign m_tdata  = head[7:0];
    assign m_tlast  = head[8];
    assign m_tuser  = head[9];

    mp2_cfg u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wr_data(cfg_wr_data),
        .restart    (restart),
        .geom       (geom)
    );

    mp2_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .restart(restart),
        .accept (accept),
        .pixel  (s_tdata),
        .geom   (geom),
        .st     (st)
    );

    mp2_colmem u_colmem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .st       (st),
        .push     (push),
        .push_data(push_data),
        .busy     (busy)
    );

    mp2_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_data(push_data),
        .pop      (m_tvalid && m_tready),
        .valid    (m_tvalid),
        .head     (head),
        .count    (q_count)
    );

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count <= (mp2_pkg::OUTQ_PTR_W+1)'(mp2_pkg::OUTQ_DEPTH))
        else $error("output queue overflow");

    a_emit_needs_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (st.valid && st.emit) |-> (st.act[st.lane]))
        else $error("result emitted from an inactive partial slot");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result visible after reset");

endmodule
